### hw/rtl/iou_box_dedup_table_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef IOU_BOX_DEDUP_TABLE_MACROS_SVH
`define IOU_BOX_DEDUP_TABLE_MACROS_SVH

// Same-cycle property, sampled on the rising edge, off during reset.
`define IOUBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define IOUBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ioubd_pkg.sv
package ioubd_pkg;

   // opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // result actions
   localparam logic [2:0] ACT_APPENDED = 3'd0;
   localparam logic [2:0] ACT_REPLACED = 3'd1;
   localparam logic [2:0] ACT_KEPT     = 3'd2;
   localparam logic [2:0] ACT_FULL     = 3'd3;
   localparam logic [2:0] ACT_CLEARED  = 3'd4;
   localparam logic [2:0] ACT_READ     = 3'd5;
   localparam logic [2:0] ACT_BADIDX   = 3'd6;

   // register indexes
   localparam logic [1:0] CSR_NUM = 2'd0;
   localparam logic [1:0] CSR_DEN = 2'd1;

   localparam int BOX_W  = 48;
   localparam int INFO_W = 26;
   localparam int INTER_W = 24;
   localparam int UNI_W   = 25;

   typedef struct packed {
      logic               valid;
      logic [INTER_W-1:0] inter;
      logic [UNI_W-1:0]   uni;
   } iou_res_type;

endpackage

### hw/rtl/iou_box_dedup_table.sv
// Steps: an insert scans the stored entries through the IoU pipeline, then passes
//   threshold, fetch, decide and emit; a read passes fetch, decide and emit.
// A clear passes decide and emit only.
// Flow: one item at a time; an insert's scan over the box memory read port sets
//   the pace, and a new request is taken only once the last result is registered.
// Reset: synchronous, active high; clears the entry count and the handshakes and sets the
//   threshold to 2/5. Memory contents are not cleared and need no clearing pass.
module iou_box_dedup_table #(
   parameter int TABLE_DEPTH = 2048
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [11:0] req_box_left,
   input  logic [11:0] req_box_top,
   input  logic [11:0] req_box_right,
   input  logic [11:0] req_box_bottom,
   input  logic [9:0]  req_confidence,
   input  logic [15:0] req_text_tag,
   input  logic [10:0] req_entry_index,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [10:0] rsp_slot,
   output logic [11:0] rsp_out_left,
   output logic [11:0] rsp_out_top,
   output logic [11:0] rsp_out_right,
   output logic [11:0] rsp_out_bottom,
   output logic [9:0]  rsp_out_confidence,
   output logic [15:0] rsp_out_tag,
   output logic [11:0] rsp_entry_total,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_THRESH, ST_FETCH, ST_DECIDE, ST_EMIT
   } state_type;

   state_type state_ff;

   // latched item
   logic [1:0]   op_ff;
   logic [47:0]  nbox_ff;
   logic [9:0]   conf_ff;
   logic [15:0]  tag_ff;
   logic [AW-1:0] idx_ff;
   logic         idx_ok_ff;

   // table state and threshold
   logic [CW-1:0] count_ff;
   logic [7:0]    num_ff, den_ff;

   // scan
   logic [CW-1:0] scan_ptr_ff;
   logic          issue_v_ff;
   logic [AW-1:0] issue_idx_ff;
   logic [23:0]   best_in_ff;
   logic [24:0]   best_un_ff;
   logic [AW-1:0] best_idx_ff;
   logic          match_ff;

   // staged result
   logic [2:0]   res_act_ff;
   logic [10:0]  res_slot_ff;
   logic [47:0]  res_box_ff;
   logic [25:0]  res_info_ff;

   // output register
   logic         rsp_valid_ff;
   logic [2:0]   rsp_action_ff;
   logic [10:0]  rsp_slot_ff;
   logic [47:0]  rsp_box_ff;
   logic [25:0]  rsp_info_ff;
   logic [11:0]  rsp_total_ff;

   // memories
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [47:0]   box_rd;
   logic [25:0]   info_rd, nbinfo;

   ioubd_pkg::iou_res_type iou_res;
   logic [AW-1:0] iou_idx;
   logic          iou_busy;

   logic          req_fire;
   logic [31:0]   idx_wide, cnt_wide, total_wide;
   logic [48:0]   cand_lhs, cand_rhs;
   logic [33:0]   thr_lhs, thr_rhs;

   // decide-stage results
   logic [2:0]    dec_act;
   logic [AW-1:0] dec_slot;
   logic          dec_show, dec_inc;
   logic [47:0]   dec_box;
   logic [25:0]   dec_info;
   logic [31:0]   dec_slot_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign nbinfo    = {tag_ff, conf_ff};
   assign idx_wide  = 32'(req_entry_index);
   assign cnt_wide  = 32'(count_ff);
   assign total_wide = 32'(count_ff);

   assign rd_addr = (state_ff == ST_SCAN) ? scan_ptr_ff[AW-1:0] :
                    (op_ff == ioubd_pkg::OP_READ) ? idx_ff : best_idx_ff;

   ioubd_ram #(.WIDTH(ioubd_pkg::BOX_W), .DEPTH(TABLE_DEPTH)) u_box_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (nbox_ff),
      .rd_addr (rd_addr),
      .rd_data (box_rd)
   );

   ioubd_ram #(.WIDTH(ioubd_pkg::INFO_W), .DEPTH(TABLE_DEPTH)) u_info_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (nbinfo),
      .rd_addr (rd_addr),
      .rd_data (info_rd)
   );

   ioubd_iou #(.AW(AW)) u_iou (
      .clock   (clock),
      .reset   (reset),
      .in_valid(issue_v_ff),
      .in_idx  (issue_idx_ff),
      .old_box (box_rd),
      .new_box (nbox_ff),
      .res     (iou_res),
      .res_idx (iou_idx),
      .busy    (iou_busy)
   );

   // strictly better IoU only, so ties keep the lowest index
   assign cand_lhs = 49'(iou_res.inter) * 49'(best_un_ff);
   assign cand_rhs = 49'(best_in_ff) * 49'(iou_res.uni);
   // threshold test inter/uni > num/den, cross-multiplied; den of zero never merges
   assign thr_lhs  = 34'(best_in_ff) * 34'(den_ff);
   assign thr_rhs  = 34'(num_ff) * 34'(best_un_ff);

   always_comb begin
      dec_act  = ioubd_pkg::ACT_CLEARED;
      dec_slot = '0;
      dec_show = 1'b0;
      dec_inc  = 1'b0;
      dec_box  = box_rd;
      dec_info = info_rd;
      wr_en    = 1'b0;
      wr_addr  = best_idx_ff;
      if (state_ff == ST_DECIDE) begin
         priority if (op_ff == ioubd_pkg::OP_CLEAR) begin
            dec_act = ioubd_pkg::ACT_CLEARED;
         end else if (op_ff == ioubd_pkg::OP_READ) begin
            if (idx_ok_ff) begin
               dec_act  = ioubd_pkg::ACT_READ;
               dec_slot = idx_ff;
               dec_show = 1'b1;
            end else begin
               dec_act = ioubd_pkg::ACT_BADIDX;
            end
         end else if (match_ff) begin
            dec_slot = best_idx_ff;
            dec_show = 1'b1;
            if (conf_ff > info_rd[9:0]) begin
               dec_act  = ioubd_pkg::ACT_REPLACED;
               dec_box  = nbox_ff;
               dec_info = nbinfo;
               wr_en    = 1'b1;
            end else begin
               dec_act = ioubd_pkg::ACT_KEPT;
            end
         end else if (count_ff == CW'(TABLE_DEPTH)) begin
            dec_act = ioubd_pkg::ACT_FULL;
         end else begin
            dec_act  = ioubd_pkg::ACT_APPENDED;
            dec_slot = count_ff[AW-1:0];
            dec_show = 1'b1;
            dec_box  = nbox_ff;
            dec_info = nbinfo;
            dec_inc  = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = count_ff[AW-1:0];
         end
      end
      dec_slot_wide = 32'(dec_slot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         num_ff       <= 8'd2;
         den_ff       <= 8'd5;
         issue_v_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ioubd_pkg::CSR_NUM: num_ff <= csr_data;
               ioubd_pkg::CSR_DEN: den_ff <= csr_data;
               default: ;
            endcase
         end

         // in the emit state the output register is reloaded below instead
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         // one stored entry goes into the IoU pipeline per scan cycle
         issue_v_ff <= (state_ff == ST_SCAN) && (scan_ptr_ff != count_ff);
         if (iou_res.valid && (cand_lhs > cand_rhs)) begin
            best_in_ff  <= iou_res.inter;
            best_un_ff  <= iou_res.uni;
            best_idx_ff <= iou_idx;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff       <= req_opcode;
                  nbox_ff     <= {req_box_bottom, req_box_right, req_box_top, req_box_left};
                  conf_ff     <= req_confidence;
                  tag_ff      <= req_text_tag;
                  idx_ff      <= idx_wide[AW-1:0];
                  idx_ok_ff   <= (idx_wide < cnt_wide);
                  scan_ptr_ff <= '0;
                  best_in_ff  <= '0;
                  best_un_ff  <= 25'd1;
                  best_idx_ff <= '0;
                  match_ff    <= 1'b0;
                  unique case (req_opcode)
                     ioubd_pkg::OP_INSERT: state_ff <= ST_SCAN;
                     ioubd_pkg::OP_CLEAR:  state_ff <= ST_DECIDE;
                     ioubd_pkg::OP_READ:   state_ff <= ST_FETCH;
                     default:              state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_ptr_ff != count_ff) begin
                  issue_idx_ff <= scan_ptr_ff[AW-1:0];
                  scan_ptr_ff  <= scan_ptr_ff + 1'b1;
               end else if (!issue_v_ff && !iou_busy) begin
                  state_ff <= ST_THRESH;
               end
            end
            ST_THRESH: begin
               match_ff <= (thr_lhs > thr_rhs);
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               res_act_ff  <= dec_act;
               res_slot_ff <= dec_slot_wide[10:0];
               res_box_ff  <= dec_show ? dec_box : '0;
               res_info_ff <= dec_show ? dec_info : '0;
               if (op_ff == ioubd_pkg::OP_CLEAR) begin
                  count_ff <= '0;
               end else if (dec_inc) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_action_ff <= res_act_ff;
                  rsp_slot_ff   <= res_slot_ff;
                  rsp_box_ff    <= res_box_ff;
                  rsp_info_ff   <= res_info_ff;
                  rsp_total_ff  <= total_wide[11:0];
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_out_left       = rsp_box_ff[11:0];
   assign rsp_out_top        = rsp_box_ff[23:12];
   assign rsp_out_right      = rsp_box_ff[35:24];
   assign rsp_out_bottom     = rsp_box_ff[47:36];
   assign rsp_out_confidence = rsp_info_ff[9:0];
   assign rsp_out_tag        = rsp_info_ff[25:10];
   assign rsp_entry_total    = rsp_total_ff;
endmodule

### hw/rtl/ioubd_ram.sv
module ioubd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/ioubd_iou.sv
// Two-stage IoU datapath: overlap and areas, then union and validity.
module ioubd_iou #(
   parameter int AW = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [AW-1:0]             in_idx,
   input  logic [ioubd_pkg::BOX_W-1:0] old_box,
   input  logic [ioubd_pkg::BOX_W-1:0] new_box,
   output ioubd_pkg::iou_res_type    res,
   output logic [AW-1:0]             res_idx,
   output logic                      busy
);
   logic [11:0] al, at, ar, ab, bl, bt, br, bb;
   logic [11:0] x1, y1, x2, y2;
   logic signed [12:0] iw_s, ih_s, daw, dah, dbw, dbh;
   logic [11:0] iw, ih;

   logic                s1_v_ff;
   logic [AW-1:0]       s1_idx_ff;
   logic [23:0]         s1_in_ff;
   logic signed [25:0]  s1_ara_ff, s1_arb_ff;

   logic signed [27:0]  un;
   ioubd_pkg::iou_res_type res_ff;
   logic [AW-1:0]       res_idx_ff;

   always_comb begin
      al = old_box[11:0];  at = old_box[23:12];
      ar = old_box[35:24]; ab = old_box[47:36];
      bl = new_box[11:0];  bt = new_box[23:12];
      br = new_box[35:24]; bb = new_box[47:36];
      x1 = (al > bl) ? al : bl;
      y1 = (at > bt) ? at : bt;
      x2 = (ar < br) ? ar : br;
      y2 = (ab < bb) ? ab : bb;
      iw_s = $signed({1'b0, x2}) - $signed({1'b0, x1});
      ih_s = $signed({1'b0, y2}) - $signed({1'b0, y1});
      iw = iw_s[12] ? 12'd0 : iw_s[11:0];
      ih = ih_s[12] ? 12'd0 : ih_s[11:0];
      daw = $signed({1'b0, ar}) - $signed({1'b0, al});
      dah = $signed({1'b0, ab}) - $signed({1'b0, at});
      dbw = $signed({1'b0, br}) - $signed({1'b0, bl});
      dbh = $signed({1'b0, bb}) - $signed({1'b0, bt});
   end

   always_comb begin
      un = 28'(s1_ara_ff) + 28'(s1_arb_ff) - $signed({4'd0, s1_in_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         s1_v_ff      <= in_valid;
         res_ff.valid <= s1_v_ff;
      end
      s1_idx_ff <= in_idx;
      s1_in_ff  <= iw * ih;
      s1_ara_ff <= daw * dah;
      s1_arb_ff <= dbw * dbh;

      res_idx_ff <= s1_idx_ff;
      if (s1_in_ff != 24'd0 && un > 28'sd0) begin
         res_ff.inter <= s1_in_ff;
         res_ff.uni   <= un[24:0];
      end else begin
         res_ff.inter <= '0;
         res_ff.uni   <= 25'd1;
      end
   end

   assign res     = res_ff;
   assign res_idx = res_idx_ff;
   assign busy    = s1_v_ff | res_ff.valid;
endmodule

### hw/rtl/ioubd_chk.sv
`include "iou_box_dedup_table_macros.svh"

module ioubd_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_action,
   input logic [10:0] rsp_slot,
   input logic [11:0] rsp_out_left,
   input logic [11:0] rsp_out_top,
   input logic [11:0] rsp_out_right,
   input logic [11:0] rsp_out_bottom,
   input logic [9:0]  rsp_out_confidence,
   input logic [15:0] rsp_out_tag,
   input logic [11:0] rsp_entry_total
);
   logic take_known;
   logic clear_seen;
   logic blank_act;
   logic blank_data;

   // an item with a known opcode was taken
   assign take_known = req_valid && req_ready &&
                       (req_opcode == ioubd_pkg::OP_INSERT ||
                        req_opcode == ioubd_pkg::OP_CLEAR ||
                        req_opcode == ioubd_pkg::OP_READ);
   assign clear_seen = rsp_valid && rsp_action == ioubd_pkg::ACT_CLEARED;
   assign blank_act  = rsp_valid && (rsp_action == ioubd_pkg::ACT_FULL ||
                                     rsp_action == ioubd_pkg::ACT_CLEARED ||
                                     rsp_action == ioubd_pkg::ACT_BADIDX);
   assign blank_data = rsp_slot == 11'd0 && rsp_out_left == 12'd0 &&
                       rsp_out_top == 12'd0 && rsp_out_right == 12'd0 &&
                       rsp_out_bottom == 12'd0 && rsp_out_confidence == 10'd0 &&
                       rsp_out_tag == 16'd0;

   `IOUBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "item dropped")
   `IOUBD_ASSERT_NEXT(a_busy_after_take, clock, reset, take_known, !req_ready, "took item while busy")
   `IOUBD_ASSERT(a_clear_empty, clock, reset, !clear_seen || rsp_entry_total == 12'd0, "clear left entries")
   `IOUBD_ASSERT(a_blank_result, clock, reset, !blank_act || blank_data, "result without entry shows data")
endmodule

bind iou_box_dedup_table ioubd_chk u_ioubd_chk (.*);

### sim/iou_box_dedup_table_tb.sv
module iou_box_dedup_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 2048;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam logic [1:0] OP_NONE = 2'd3;   // opcode the block ignores

   // one result item as seen on the rsp_ ports
   typedef struct {
      logic [2:0]  action;
      logic [10:0] slot;
      logic [11:0] left, top, right, bottom;
      logic [9:0]  conf;
      logic [15:0] tag;
      logic [11:0] total;
   } table_result_type;

   // Scoreboard: private copy of the box table, works out each expected result
   class dedup_scoreboard;
      logic [11:0] bx_l [DEPTH];
      logic [11:0] bx_t [DEPTH];
      logic [11:0] bx_r [DEPTH];
      logic [11:0] bx_b [DEPTH];
      logic [9:0]  bx_conf [DEPTH];
      logic [15:0] bx_tag [DEPTH];
      int unsigned count;
      logic [7:0]  ratio_num, ratio_den;
      table_result_type pending[$];
      int errors;

      function new();
         count = 0; ratio_num = 2; ratio_den = 5; errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] d);
         if (idx == ioubd_pkg::CSR_NUM) ratio_num = d;
         else if (idx == ioubd_pkg::CSR_DEN) ratio_den = d;
      endfunction

      // overlap ratio as inter/uni; zero overlap or non-positive union gives 0/1
      function void overlap(int j, longint l, longint t, longint r, longint b,
                            output longint inter, output longint uni);
         longint x1, y1, x2, y2, iw, ih, ov, aa, ab, un;
         x1 = (bx_l[j] > l) ? bx_l[j] : l;
         y1 = (bx_t[j] > t) ? bx_t[j] : t;
         x2 = (bx_r[j] < r) ? bx_r[j] : r;
         y2 = (bx_b[j] < b) ? bx_b[j] : b;
         iw = x2 - x1; ih = y2 - y1;
         if (iw < 0) iw = 0;
         if (ih < 0) ih = 0;
         ov = iw * ih;
         inter = 0; uni = 1;
         if (ov == 0) return;
         aa = (longint'(bx_r[j]) - longint'(bx_l[j])) *
              (longint'(bx_b[j]) - longint'(bx_t[j]));
         ab = (r - l) * (b - t);
         un = aa + ab - ov;
         if (un > 0) begin
            inter = ov; uni = un;
         end
      endfunction

      function table_result_type show(logic [2:0] act, int s, bit vis);
         table_result_type e;
         e.action = act;
         e.slot = vis ? 11'(s) : '0;
         e.left = vis ? bx_l[s] : '0;
         e.top = vis ? bx_t[s] : '0;
         e.right = vis ? bx_r[s] : '0;
         e.bottom = vis ? bx_b[s] : '0;
         e.conf = vis ? bx_conf[s] : '0;
         e.tag = vis ? bx_tag[s] : '0;
         e.total = 12'(count);
         return e;
      endfunction

      function void note_request(logic [1:0] op, logic [11:0] l, t, r, b,
                                 logic [9:0] cf, logic [15:0] tg, logic [10:0] idx);
         longint bi, bu, ii, uu;
         int best;
         if (op == ioubd_pkg::OP_INSERT) begin
            bi = 0; bu = 1; best = 0;
            for (int j = 0; j < count; j++) begin
               overlap(j, l, t, r, b, ii, uu);
               if (ii * bu > bi * uu) begin
                  bi = ii; bu = uu; best = j;
               end
            end
            if (bi * longint'(ratio_den) > longint'(ratio_num) * bu) begin
               if (cf > bx_conf[best]) begin
                  bx_l[best] = l; bx_t[best] = t; bx_r[best] = r; bx_b[best] = b;
                  bx_conf[best] = cf; bx_tag[best] = tg;
                  pending.push_back(show(ioubd_pkg::ACT_REPLACED, best, 1));
               end else
                  pending.push_back(show(ioubd_pkg::ACT_KEPT, best, 1));
            end else if (count >= DEPTH)
               pending.push_back(show(ioubd_pkg::ACT_FULL, 0, 0));
            else begin
               bx_l[count] = l; bx_t[count] = t; bx_r[count] = r; bx_b[count] = b;
               bx_conf[count] = cf; bx_tag[count] = tg;
               count++;
               pending.push_back(show(ioubd_pkg::ACT_APPENDED, count - 1, 1));
            end
         end else if (op == ioubd_pkg::OP_CLEAR) begin
            count = 0;
            pending.push_back(show(ioubd_pkg::ACT_CLEARED, 0, 0));
         end else if (op == ioubd_pkg::OP_READ) begin
            if (idx < count) pending.push_back(show(ioubd_pkg::ACT_READ, idx, 1));
            else pending.push_back(show(ioubd_pkg::ACT_BADIDX, 0, 0));
         end
      endfunction

      function void check_result(table_result_type got);
         table_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item, action %0d", got.action);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.action !== e.action) begin
            $error("action exp %0d got %0d", e.action, got.action); errors++;
         end
         if (got.slot !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
         end
         if (got.left !== e.left) begin
            $error("out_left exp %0d got %0d", e.left, got.left); errors++;
         end
         if (got.top !== e.top) begin
            $error("out_top exp %0d got %0d", e.top, got.top); errors++;
         end
         if (got.right !== e.right) begin
            $error("out_right exp %0d got %0d", e.right, got.right); errors++;
         end
         if (got.bottom !== e.bottom) begin
            $error("out_bottom exp %0d got %0d", e.bottom, got.bottom); errors++;
         end
         if (got.conf !== e.conf) begin
            $error("out_confidence exp %0d got %0d", e.conf, got.conf); errors++;
         end
         if (got.tag !== e.tag) begin
            $error("out_tag exp %0d got %0d", e.tag, got.tag); errors++;
         end
         if (got.total !== e.total) begin
            $error("entry_total exp %0d got %0d", e.total, got.total); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_ready;
   logic [1:0]  req_opcode = '0;
   logic [11:0] req_box_left = '0, req_box_top = '0, req_box_right = '0, req_box_bottom = '0;
   logic [9:0]  req_confidence = '0;
   logic [15:0] req_text_tag = '0;
   logic [10:0] req_entry_index = '0;
   logic        rsp_valid, rsp_ready = 0;
   logic [2:0]  rsp_action;
   logic [10:0] rsp_slot;
   logic [11:0] rsp_out_left, rsp_out_top, rsp_out_right, rsp_out_bottom;
   logic [9:0]  rsp_out_confidence;
   logic [15:0] rsp_out_tag;
   logic [11:0] rsp_entry_total;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   dedup_scoreboard table_sb = new();
   int  cycle_count = 0;
   bit  idle_free = 0;     // long stretch with no idling on either side
   bit  sink_hold = 0;     // receiver held off for back-pressure
   bit  stim_done = 0;

   always #5 clock = ~clock;

   iou_box_dedup_table u_dut (.*);

   // safety net
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("iou_box_dedup_table: mismatch");
         $finish;
      end
   end

   // result side: sample at the rising edge, drive ready at the falling edge
   always @(posedge clock) begin
      table_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.action = rsp_action; got.slot = rsp_slot;
         got.left = rsp_out_left; got.top = rsp_out_top;
         got.right = rsp_out_right; got.bottom = rsp_out_bottom;
         got.conf = rsp_out_confidence; got.tag = rsp_out_tag;
         got.total = rsp_entry_total;
         table_sb.check_result(got);
      end
   end

   always @(negedge clock) begin
      if (sink_hold) rsp_ready <= 0;
      else if (idle_free) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(99) >= 26);
   end

   // Send one item; valid stays up until accepted, then scoreboard notes it.
   // Valid drops only when the sender idles or the stream stops.
   task automatic send_item(logic [1:0] op, logic [11:0] l, t, r, b,
                            logic [9:0] cf, logic [15:0] tg, logic [10:0] idx);
      if (!idle_free)
         while ($urandom_range(99) < 26) begin
            req_valid <= 0;
            @(negedge clock);
         end
      req_valid <= 1; req_opcode <= op;
      req_box_left <= l; req_box_top <= t; req_box_right <= r; req_box_bottom <= b;
      req_confidence <= cf; req_text_tag <= tg; req_entry_index <= idx;
      do @(posedge clock); while (!req_ready);
      table_sb.note_request(op, l, t, r, b, cf, tg, idx);
      @(negedge clock);
   endtask

   task automatic send_box(logic [11:0] l, t, r, b, logic [9:0] cf, logic [15:0] tg);
      send_item(ioubd_pkg::OP_INSERT, l, t, r, b, cf, tg, '0);
   endtask

   // Register write: only called with the block idle
   task automatic write_reg(logic [1:0] idx, logic [7:0] d);
      csr_valid <= 1; csr_index <= idx; csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      table_sb.set_reg(idx, d);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   // stop offering, wait for all results, plus slack for an ignored opcode
   task automatic drain();
      req_valid <= 0;
      while (table_sb.pending.size() != 0) @(negedge clock);
      repeat (table_sb.count + 20) @(negedge clock);
   endtask

   // random box, mostly near an existing one so merges actually happen
   task automatic random_box();
      logic [11:0] l, t, r, b;
      int j, d;
      if (table_sb.count != 0 && $urandom_range(99) < 55) begin
         j = $urandom_range(table_sb.count - 1);
         d = $urandom_range(12);
         l = table_sb.bx_l[j] + 12'($urandom_range(2 * d)) - 12'(d);
         t = table_sb.bx_t[j] + 12'($urandom_range(2 * d)) - 12'(d);
         r = table_sb.bx_r[j] + 12'($urandom_range(2 * d)) - 12'(d);
         b = table_sb.bx_b[j] + 12'($urandom_range(2 * d)) - 12'(d);
      end else if ($urandom_range(99) < 10) begin
         // any shape, inverted too
         l = 12'($urandom); t = 12'($urandom); r = 12'($urandom); b = 12'($urandom);
      end else begin
         l = 12'($urandom_range(3900)); t = 12'($urandom_range(3900));
         r = l + 12'($urandom_range(195)); b = t + 12'($urandom_range(195));
      end
      send_box(l, t, r, b, 10'($urandom), 16'($urandom));
   endtask

   task automatic random_phase(int n);
      int p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(99);
         if (p < 75) random_box();
         else if (p < 90) send_item(ioubd_pkg::OP_READ, 12'($urandom), 12'($urandom),
                                    12'($urandom), 12'($urandom),
                                    10'($urandom), 16'($urandom),
                                    ($urandom_range(3) == 0) ? 11'($urandom)
                                       : 11'($urandom_range(table_sb.count + 1)));
         else if (p < 94) send_item(ioubd_pkg::OP_CLEAR, 12'($urandom), 12'($urandom),
                                    12'($urandom), 12'($urandom),
                                    10'($urandom), 16'($urandom), 11'($urandom));
         else send_item(OP_NONE, 12'($urandom), 12'($urandom),
                        12'($urandom), 12'($urandom),
                        10'($urandom), 16'($urandom), 11'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, every operation, each corner of the overlap maths
      send_item(ioubd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);             // read on empty table
      send_box(12'd100, 12'd100, 12'd200, 12'd200, 10'd500, 16'h1234);
      send_box(12'd100, 12'd100, 12'd200, 12'd200, 10'd400, 16'h0001);  // same box, lower conf
      send_box(12'd102, 12'd101, 12'd201, 12'd199, 10'd1023, 16'hFFFF); // higher conf: replace
      send_box(12'd300, 12'd300, 12'd300, 12'd400, 10'd0, 16'h0);      // zero width
      send_box(12'd4095, 12'd4095, 12'd0, 12'd0, 10'd700, 16'hAAAA);   // inverted
      send_box(12'd0, 12'd0, 12'd4095, 12'd4095, 10'd900, 16'h5555);   // full frame
      send_box(12'd150, 12'd150, 12'd250, 12'd250, 10'd1023, 16'h7777); // partial overlap
      send_box(12'd200, 12'd100, 12'd300, 12'd200, 10'd1000, 16'h2);    // thin overlap with the first entry
      send_item(ioubd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 11'd0);
      send_item(ioubd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 11'd6);
      send_item(ioubd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 11'd2047);
      send_item(OP_NONE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 10'h3FF, 16'hFFFF, 11'h7FF);
      send_item(ioubd_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_item(ioubd_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 11'd0);
      drain();

      // zero denominator: nothing merges
      write_reg(ioubd_pkg::CSR_DEN, 8'd0);
      write_reg(ioubd_pkg::CSR_NUM, 8'd255);
      send_box(12'd10, 12'd10, 12'd20, 12'd20, 10'd1, 16'd1);
      send_box(12'd10, 12'd10, 12'd20, 12'd20, 10'd9, 16'd2);
      drain();

      // threshold zero: any overlap merges; receiver held off meanwhile
      write_reg(ioubd_pkg::CSR_NUM, 8'd0);
      write_reg(ioubd_pkg::CSR_DEN, 8'd255);
      fork
         begin
            sink_hold = 1;
            repeat (400) @(negedge clock);
            sink_hold = 0;
         end
         random_phase(40);
      join
      drain();

      // default-like threshold, first with no idling at all, then with idling
      write_reg(ioubd_pkg::CSR_NUM, 8'd2);
      write_reg(ioubd_pkg::CSR_DEN, 8'd5);
      idle_free = 1;
      random_phase(60);
      idle_free = 0;
      random_phase(60);
      drain();

      // high threshold, then a ratio of one, then one third
      write_reg(ioubd_pkg::CSR_NUM, 8'd9);
      write_reg(ioubd_pkg::CSR_DEN, 8'd10);
      random_phase(60);
      drain();
      write_reg(ioubd_pkg::CSR_NUM, 8'd1);
      write_reg(ioubd_pkg::CSR_DEN, 8'd1);
      random_phase(30);
      drain();
      write_reg(ioubd_pkg::CSR_NUM, 8'd1);
      write_reg(ioubd_pkg::CSR_DEN, 8'd3);
      random_phase(40);

      drain();
      stim_done = 1;
      if (table_sb.errors == 0 && table_sb.pending.size() == 0)
         $display("iou_box_dedup_table: match");
      else
         $display("iou_box_dedup_table: mismatch");
      $finish;
   end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ioubd_pkg.sv
hw/rtl/ioubd_ram.sv
hw/rtl/ioubd_iou.sv
hw/rtl/iou_box_dedup_table.sv
hw/rtl/ioubd_chk.sv
sim/iou_box_dedup_table_tb.sv
